>>> sv/grid_code_cluster_lookup_core_assert.svh
// Assertion macros used by the checker file.
`ifndef GRID_CODE_CLUSTER_LOOKUP_CORE_ASSERT_SVH
`define GRID_CODE_CLUSTER_LOOKUP_CORE_ASSERT_SVH
// Implication checked at every rising clock edge outside reset.
`define GCL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define GCL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> sv/gcl_pkg.sv
`default_nettype none
package gcl_pkg;
    localparam int MAX_DIMS_DEF    = 10;
    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int VALUE_BITS_DEF  = 16;
    localparam int CELL_BITS       = 6;
    localparam int CODE_BITS       = 60;
    localparam int TAG_BITS        = 16;
    localparam int DIV_NUM_BITS    = 38;
    localparam int DIV_DEN_BITS    = 33;
    localparam logic [5:0] CELL_MAX = 6'd63;
    localparam logic [5:0] DIV_MIN  = 6'd5;
    localparam logic [5:0] DIV_MAX  = 6'd51;
    localparam logic [1:0] CMD_RANGE = 2'd0;
    localparam logic [1:0] CMD_ENTRY = 2'd1;
    localparam logic [1:0] CMD_COMP  = 2'd2;
    localparam logic [1:0] REG_DIMS  = 2'd0;
    localparam logic [1:0] REG_DIV   = 2'd1;
    localparam logic [1:0] REG_COUNT = 2'd2;

    // Divider request from the sequencer.
    typedef struct packed {
        logic                    go;
        logic [DIV_NUM_BITS-1:0] num;
        logic [DIV_DEN_BITS-1:0] den;
    } t_div_req;
endpackage
`default_nettype wire

>>> sv/gcl_divider.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle, quotient saturated to 63.
module gcl_divider (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire gcl_pkg::t_div_req   i_req,
    output logic                     o_done,
    output logic [5:0]               o_cell
);
    localparam int NUM_BITS = gcl_pkg::DIV_NUM_BITS;
    localparam int DEN_BITS = gcl_pkg::DIV_DEN_BITS;
    localparam int CNT_BITS = $clog2(NUM_BITS + 1);
    logic [NUM_BITS-1:0] r_num;
    logic [DEN_BITS:0]   r_rem;
    logic [DEN_BITS-1:0] r_den;
    logic [NUM_BITS-1:0] r_quo;
    logic [CNT_BITS-1:0] r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [DEN_BITS:0]   n_shift;
    logic [DEN_BITS:0]   n_diff;

    always_comb begin
        n_shift = {r_rem[DEN_BITS-1:0], r_num[NUM_BITS-1]};
        n_diff  = n_shift - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_busy <= 1'b1;
                r_num  <= NUM_BITS'(i_req.num);
                r_den  <= DEN_BITS'(i_req.den);
                r_rem  <= '0;
                r_quo  <= '0;
                r_cnt  <= CNT_BITS'(NUM_BITS);
            end else if (r_busy) begin
                r_num <= {r_num[NUM_BITS-2:0], 1'b0};
                if (!n_diff[DEN_BITS]) begin
                    r_rem <= n_diff;
                    r_quo <= {r_quo[NUM_BITS-2:0], 1'b1};
                end else begin
                    r_rem <= n_shift;
                    r_quo <= {r_quo[NUM_BITS-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_cell = (r_quo > NUM_BITS'(gcl_pkg::CELL_MAX)) ? gcl_pkg::CELL_MAX : r_quo[5:0];
endmodule
`default_nettype wire

>>> sv/grid_code_cluster_lookup_core.sv
// Loads and components that need no division complete as they are accepted; a component
// that needs the 38-step divider holds busy for the divide and the write-back of its cell.
// A last component then searches the table entry by entry (a read state, then a compare
// state) until a match or the count's end. One item at a time: start is ignored while busy.
// Results appear for one cycle on o_valid; the receiver cannot stall.
// Reset (synchronous, active low) restores the registers, ranges and code word.
`default_nettype none
module grid_code_cluster_lookup_core #(
    parameter int MAX_DIMS    = gcl_pkg::MAX_DIMS_DEF,
    parameter int TABLE_DEPTH = gcl_pkg::TABLE_DEPTH_DEF,
    parameter int VALUE_BITS  = gcl_pkg::VALUE_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [1:0]             i_cfg_index,
    input  wire logic [12:0]            i_cfg_data,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic [1:0]             i_command,
    input  wire logic [11:0]            i_slot,
    input  wire logic signed [VALUE_BITS-1:0] i_sample,
    input  wire logic signed [VALUE_BITS-1:0] i_upper_bound,
    input  wire logic [59:0]            i_word_code,
    input  wire logic [15:0]            i_cluster_tag,
    input  wire logic                   i_last,
    output logic                        o_valid,
    output logic [15:0]                 o_cluster_out,
    output logic                        o_found
);
    localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int DW   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int DENW = VALUE_BITS + 1;
    localparam int NUMW = VALUE_BITS + 1 + 6;
    localparam int CB   = gcl_pkg::CELL_BITS;
    localparam int DNB  = gcl_pkg::DIV_NUM_BITS;
    localparam int DDB  = gcl_pkg::DIV_DEN_BITS;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_SRCH = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;

    logic [3:0]  r_dims;
    logic [5:0]  r_div;
    logic [12:0] r_count;
    logic [2:0]  r_state;
    logic signed [VALUE_BITS-1:0] r_lo [MAX_DIMS];
    logic signed [VALUE_BITS-1:0] r_hi [MAX_DIMS];
    logic [59:0] r_word_mem [TABLE_DEPTH];
    logic [15:0] r_tag_mem  [TABLE_DEPTH];
    logic [59:0] r_rd_word;
    logic [15:0] r_rd_tag;
    logic [59:0] r_code;
    logic [59:0] r_mask;
    logic [DW-1:0] r_dslot;
    logic        r_last;
    logic [CW-1:0] r_addr;
    logic [CW-1:0] r_limit;
    logic        r_valid;
    logic [15:0] r_cl;
    logic        r_found;
    gcl_pkg::t_div_req n_req;
    logic        w_done;
    logic [5:0]  w_cell;
    logic        w_accept;
    logic [5:0]  w_div_eff;
    logic [3:0]  w_dims_eff;
    logic signed [DENW-1:0] w_range;
    logic signed [DENW-1:0] w_off;
    logic signed [NUMW-1:0] w_num;
    logic        w_dim_ok;
    logic [DW-1:0] w_ds;

    assign w_accept = start && (r_state == S_IDLE);
    assign busy = (r_state != S_IDLE);
    assign w_ds = i_slot[DW-1:0];
    assign w_dim_ok = (32'(i_slot) < MAX_DIMS);

    always_comb begin
        w_div_eff = (r_div < gcl_pkg::DIV_MIN) ? gcl_pkg::DIV_MIN :
                    (r_div > gcl_pkg::DIV_MAX) ? gcl_pkg::DIV_MAX : r_div;
        w_dims_eff = (r_dims == 4'd0) ? 4'd1 :
                     (32'(r_dims) > MAX_DIMS) ? 4'(MAX_DIMS) : r_dims;
        w_range = '0;
        w_off   = '0;
        if (w_dim_ok) begin
            w_range = DENW'(r_hi[w_ds]) - DENW'(r_lo[w_ds]);
            w_off   = DENW'(i_sample) - DENW'(r_lo[w_ds]);
        end
        w_num = NUMW'(w_off) * $signed({1'b0, w_div_eff});
        n_req.go  = 1'b0;
        n_req.num = '0;
        n_req.den = '0;
        if (w_accept && i_command == gcl_pkg::CMD_COMP && w_dim_ok
            && w_range > 0 && w_num >= 0) begin
            n_req.go  = 1'b1;
            n_req.num = DNB'(unsigned'(w_num));
            n_req.den = DDB'(unsigned'(w_range));
        end
    end

    gcl_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (n_req),
        .o_done (w_done),
        .o_cell (w_cell)
    );

    // Table memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_accept && i_command == gcl_pkg::CMD_ENTRY && 32'(i_slot) < TABLE_DEPTH) begin
            r_word_mem[i_slot[AW-1:0]] <= i_word_code;
            r_tag_mem[i_slot[AW-1:0]]  <= i_cluster_tag;
        end
        r_rd_word <= r_word_mem[r_addr[AW-1:0]];
        r_rd_tag  <= r_tag_mem[r_addr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims  <= 4'd2;
            r_div   <= 6'd5;
            r_count <= '0;
            r_state <= S_IDLE;
            r_code  <= '0;
            r_valid <= 1'b0;
            for (int k = 0; k < MAX_DIMS; k++) begin
                r_lo[k] <= '0;
                r_hi[k] <= '0;
            end
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    gcl_pkg::REG_DIMS:  r_dims  <= i_cfg_data[3:0];
                    gcl_pkg::REG_DIV:   r_div   <= i_cfg_data[5:0];
                    gcl_pkg::REG_COUNT: r_count <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_command == gcl_pkg::CMD_RANGE && w_dim_ok) begin
                            r_lo[w_ds] <= i_sample;
                            r_hi[w_ds] <= i_upper_bound;
                        end else if (i_command == gcl_pkg::CMD_COMP) begin
                            r_dslot <= w_ds;
                            r_last  <= i_last;
                            r_mask  <= ~(60'hFFF_FFFF_FFFF_FFFF << (w_dims_eff * CB));
                            r_limit <= (32'(r_count) > TABLE_DEPTH) ? CW'(TABLE_DEPTH)
                                                                    : CW'(r_count);
                            r_addr  <= '0;
                            if (n_req.go) begin
                                r_state <= S_DIV;
                            end else begin
                                if (w_dim_ok) begin
                                    r_code <= r_code & ~(60'(gcl_pkg::CELL_MAX) << (w_ds * CB));
                                end
                                if (i_last) r_state <= S_SRCH;
                            end
                        end
                    end
                end
                S_DIV: begin
                    if (w_done) begin
                        r_code <= (r_code & ~(60'(gcl_pkg::CELL_MAX) << (r_dslot * CB)))
                                  | (60'(w_cell) << (r_dslot * CB));
                        r_state <= r_last ? S_SRCH : S_IDLE;
                    end
                end
                S_SRCH: begin
                    // Issue the read of entry r_addr; compare next cycle.
                    if (r_addr >= r_limit) begin
                        r_valid <= 1'b1;
                        r_cl    <= '0;
                        r_found <= 1'b0;
                        r_code  <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (((r_rd_word ^ r_code) & r_mask) == '0) begin
                        r_valid <= 1'b1;
                        r_cl    <= r_rd_tag;
                        r_found <= 1'b1;
                        r_code  <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_addr  <= r_addr + 1'b1;
                        r_state <= S_SRCH;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid       = r_valid;
    assign o_cluster_out = r_cl;
    assign o_found       = r_found;
endmodule
`default_nettype wire

>>> sv/gcl_checker.sv
`default_nettype none
`include "grid_code_cluster_lookup_core_assert.svh"
module gcl_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        o_valid,
    input wire logic [15:0] o_cluster_out,
    input wire logic        o_found
);
    // A word is delivered only as the block finishes its work.
    `GCL_ASSERT_IMP(a_valid_idle, i_clk, i_rst_n, o_valid, !busy)
    // A miss always carries cluster zero.
    `GCL_ASSERT_IMP(a_miss_zero, i_clk, i_rst_n, o_valid && !o_found, o_cluster_out == 16'd0)
    // Busy is high in the cycle before a word.
    `GCL_ASSERT_IMP(a_busy_before, i_clk, i_rst_n, o_valid, $past(busy))
    // Results are single-cycle strobes.
    `GCL_ASSERT_NEXT(a_one_cycle, i_clk, i_rst_n, o_valid, !o_valid)
    // The block only becomes busy by accepting a word.
    `GCL_ASSERT_NEXT(a_idle_stays, i_clk, i_rst_n, !busy && !start, !busy)
endmodule

bind grid_code_cluster_lookup_core gcl_checker u_gcl_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_cluster_out(o_cluster_out),
    .o_found      (o_found)
);
`default_nettype wire
